@@ rtl/lane_min_max_argmax_unit_assert.svh @@
// ----------------------------------------------------------------------------
// lane_min_max_argmax_unit assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LANE_MIN_MAX_ARGMAX_UNIT_ASSERT_SVH
`define LANE_MIN_MAX_ARGMAX_UNIT_ASSERT_SVH

// a stalled word keeps valid high and its payload still
`define LMMA_HOLD(label, vld, rdy, dat) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (vld && !rdy) |=> (vld && $stable(dat))) \
        else $error("word dropped or changed while stalled");

// plain implication into the next cycle
`define LMMA_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("sequence check failed");

// delayed implication, outside reset
`define LMMA_NEXT2(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> ##1 (cons)) \
        else $error("result missing after last word");

`endif

@@ rtl/lmma_pkg.sv @@
// ----------------------------------------------------------------------------
// lmma_pkg
// word types and IEEE single compare helpers for the min/max/argmax unit
// ----------------------------------------------------------------------------
`default_nettype none

package lmma_pkg;

    typedef struct packed {
        logic [31:0] sample_a;
        logic [31:0] sample_b;
        logic [31:0] sample_c;
        logic [31:0] sample_d;
        logic [31:0] sample_e;
        logic [31:0] sample_f;
        logic [31:0] sample_g;
        logic [31:0] sample_h;
        logic [3:0]  valid_count;
        logic        last_beat;
    } in_word_t;

    typedef struct packed {
        logic [31:0] max_sample;
        logic [31:0] min_sample;
        logic [23:0] max_position;
        logic        run_error;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic update;
    } lane_ctrl_t;

    localparam int MaxLanes = 8;

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:0] > 31'h7f800000);
    endfunction

    // monotonic key, both zeros share one key
    function automatic logic [31:0] order_key(input logic [31:0] x);
        logic [31:0] k;
        if (x[30:0] == 31'd0) begin
            k = 32'h80000000;
        end else if (x[31]) begin
            k = ~x;
        end else begin
            k = x | 32'h80000000;
        end
        return k;
    endfunction

    function automatic logic greater(input logic [31:0] a, input logic [31:0] b);
        return !is_nan(a) && !is_nan(b) && (order_key(a) > order_key(b));
    endfunction

    function automatic logic [31:0] pick_max(input logic [31:0] cur, input logic [31:0] p);
        logic [31:0] r;
        if (is_nan(p)) begin
            r = cur;
        end else if (is_nan(cur)) begin
            r = p;
        end else begin
            r = greater(p, cur) ? p : cur;
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_min(input logic [31:0] cur, input logic [31:0] p);
        logic [31:0] r;
        if (is_nan(p)) begin
            r = cur;
        end else if (is_nan(cur)) begin
            r = p;
        end else begin
            r = greater(cur, p) ? p : cur;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lmma_lane.sv @@
// ----------------------------------------------------------------------------
// lmma_lane
// one lane: running maximum, minimum and index of the maximum
// ----------------------------------------------------------------------------
`default_nettype none

module lmma_lane #(
    parameter int INDEX_BITS = 24
) (
    input  wire                        aclk,
    input  wire lmma_pkg::lane_ctrl_t  ctrl,
    input  wire  [31:0]                sample,
    input  wire  [INDEX_BITS-1:0]      load_pos,
    input  wire  [INDEX_BITS-1:0]      idx,
    output logic [31:0]                high_next,
    output logic [31:0]                low_next,
    output logic [INDEX_BITS-1:0]      pos_next
);

    logic [31:0]           high_reg;
    logic [31:0]           low_reg;
    logic [INDEX_BITS-1:0] pos_reg;

    always_comb begin
        high_next = high_reg;
        low_next  = low_reg;
        pos_next  = pos_reg;
        if (ctrl.load) begin
            high_next = sample;
            low_next  = sample;
            pos_next  = load_pos;
        end else if (ctrl.update) begin
            // index moves only on a strictly greater sample
            if (lmma_pkg::greater(sample, high_reg)) begin
                pos_next = idx;
            end
            high_next = lmma_pkg::pick_max(high_reg, sample);
            low_next  = lmma_pkg::pick_min(low_reg, sample);
        end
    end

    always_ff @(posedge aclk) begin
        high_reg <= high_next;
        low_reg  <= low_next;
        pos_reg  <= pos_next;
    end

endmodule

`default_nettype wire

@@ rtl/lmma_merge.sv @@
// ----------------------------------------------------------------------------
// lmma_merge
// captures the lanes at the end of a run and reduces them into one result
// ----------------------------------------------------------------------------
`default_nettype none

module lmma_merge #(
    parameter int LANES      = 8,
    parameter int INDEX_BITS = 24
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          take,
    input  wire                          err_in,
    input  wire  [31:0]                  high_in [LANES],
    input  wire  [31:0]                  low_in  [LANES],
    input  wire  [INDEX_BITS-1:0]        pos_in  [LANES],
    output logic                         can_take,
    output logic                         m_valid,
    input  wire                          m_ready,
    output lmma_pkg::out_word_t          m_data
);

    typedef struct packed {
        logic                  ok;
        logic [31:0]           key;
        logic [31:0]           bits;
        logic [INDEX_BITS-1:0] pos;
    } cand_t;

    logic                  snap_valid_reg;
    logic                  snap_valid_next;
    logic                  snap_err_reg;
    logic [31:0]           snap_high_reg [LANES];
    logic [31:0]           snap_low_reg  [LANES];
    logic [INDEX_BITS-1:0] snap_pos_reg  [LANES];
    logic                  out_valid_reg;
    lmma_pkg::out_word_t   out_data_reg;
    lmma_pkg::out_word_t   out_data_next;
    logic                  out_load;

    cand_t mx0 [8];
    cand_t mn0 [8];
    cand_t mx1 [4];
    cand_t mn1 [4];
    cand_t mx2 [2];
    cand_t mn2 [2];
    cand_t mx3;
    cand_t mn3;
    logic [31:0] pos_wide;

    // ties keep the left (lower) lane; a lane that is not ok wins only against another lane that is not ok
    function automatic cand_t comb_max(input cand_t l, input cand_t r);
        return (r.ok && (!l.ok || r.key > l.key)) ? r : l;
    endfunction

    function automatic cand_t comb_min(input cand_t l, input cand_t r);
        return (r.ok && (!l.ok || r.key < l.key)) ? r : l;
    endfunction

    assign out_load = !out_valid_reg || m_ready;
    assign can_take = !snap_valid_reg || out_load;

    genvar g;
    generate
        for (g = 0; g < 8; g++) begin : g_leaf
            if (g < LANES) begin : g_used
                assign mx0[g] = '{ok: !lmma_pkg::is_nan(snap_high_reg[g]),
                                  key: lmma_pkg::order_key(snap_high_reg[g]),
                                  bits: snap_high_reg[g], pos: snap_pos_reg[g]};
                assign mn0[g] = '{ok: !lmma_pkg::is_nan(snap_low_reg[g]),
                                  key: lmma_pkg::order_key(snap_low_reg[g]),
                                  bits: snap_low_reg[g], pos: '0};
            end else begin : g_pad
                assign mx0[g] = '0;
                assign mn0[g] = '0;
            end
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mx1[i] = comb_max(mx0[2*i], mx0[2*i+1]);
            mn1[i] = comb_min(mn0[2*i], mn0[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            mx2[i] = comb_max(mx1[2*i], mx1[2*i+1]);
            mn2[i] = comb_min(mn1[2*i], mn1[2*i+1]);
        end
        mx3 = comb_max(mx2[0], mx2[1]);
        mn3 = comb_min(mn2[0], mn2[1]);
        // a NaN in lane 0 is never displaced
        if (!mx0[0].ok) begin
            mx3 = mx0[0];
        end
        if (!mn0[0].ok) begin
            mn3 = mn0[0];
        end
        pos_wide = 32'(mx3.pos);
        out_data_next.max_sample   = mx3.bits;
        out_data_next.min_sample   = mn3.bits;
        out_data_next.max_position = pos_wide[23:0];
        out_data_next.run_error    = snap_err_reg;
    end

    always_comb begin
        snap_valid_next = snap_valid_reg;
        if (take) begin
            snap_valid_next = 1'b1;
        end else if (out_load) begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
            if (out_load) begin
                out_valid_reg <= snap_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            snap_err_reg  <= err_in;
            snap_high_reg <= high_in;
            snap_low_reg  <= low_in;
            snap_pos_reg  <= pos_in;
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/lane_min_max_argmax_unit.sv @@
// ----------------------------------------------------------------------------
// lane_min_max_argmax_unit
// streaming maximum, minimum and argmax over beats of IEEE single samples
// ----------------------------------------------------------------------------
//  channel | ports            | word       | moves
//  --------+------------------+------------+------------------------------
//  input   | s_valid s_ready  | in_word_t  | one beat of up to 8 samples
//  result  | m_valid m_ready  | out_word_t | one result per last beat
//
//  one input word per cycle while s_ready is high; the lanes update in the accepting cycle
//  a result passes from its last word through a capture stage
//  and an output register; the three-level merge tree sits between them
//  reset (aresetn low, synchronous) drops any run and any pending result
//  m_ready low holds the result; while it is low and both the capture stage
//  and the output register are full, s_ready is low and every input word waits
// ----------------------------------------------------------------------------
`default_nettype none

module lane_min_max_argmax_unit #(
    parameter int LANES      = 8,
    parameter int INDEX_BITS = 24
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire lmma_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output lmma_pkg::out_word_t      m_data
);

    logic [INDEX_BITS-1:0] beat_base_reg;
    logic                  run_started_reg;
    logic                  error_seen_reg;
    logic                  error_next;

    logic                  accept;
    logic                  first;
    logic [3:0]            valid_n;
    logic                  short_beat;
    logic [INDEX_BITS:0]   base_wide;
    logic [31:0]           samp [lmma_pkg::MaxLanes];
    logic [LANES-1:0]      ovf;
    logic [31:0]           high_next [LANES];
    logic [31:0]           low_next  [LANES];
    logic [INDEX_BITS-1:0] pos_next  [LANES];
    logic                  can_take;

    assign s_ready = can_take;
    assign accept  = s_valid && s_ready;
    assign first   = !run_started_reg;

    assign samp[0] = s_data.sample_a;
    assign samp[1] = s_data.sample_b;
    assign samp[2] = s_data.sample_c;
    assign samp[3] = s_data.sample_d;
    assign samp[4] = s_data.sample_e;
    assign samp[5] = s_data.sample_f;
    assign samp[6] = s_data.sample_g;
    assign samp[7] = s_data.sample_h;

    assign valid_n    = (s_data.valid_count > 4'(LANES)) ? 4'(LANES) : s_data.valid_count;
    assign short_beat = valid_n < 4'(LANES);
    assign base_wide  = {1'b0, beat_base_reg} + (INDEX_BITS+1)'(LANES);

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            lmma_pkg::lane_ctrl_t ctrl;
            logic [INDEX_BITS:0]  idx_wide;

            assign idx_wide    = base_wide + (INDEX_BITS+1)'(g);
            assign ctrl.load   = accept && first;
            assign ctrl.update = accept && !first && (4'(g) < valid_n);
            // top bit set means the index passed the index range
            assign ovf[g]      = ctrl.update && idx_wide[INDEX_BITS];

            lmma_lane #(
                .INDEX_BITS (INDEX_BITS)
            ) u_lane (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .sample    (samp[g]),
                .load_pos  (INDEX_BITS'(g)),
                .idx       (idx_wide[INDEX_BITS-1:0]),
                .high_next (high_next[g]),
                .low_next  (low_next[g]),
                .pos_next  (pos_next[g])
            );
        end
    endgenerate

    always_comb begin
        error_next = error_seen_reg;
        if (accept) begin
            if (first) begin
                error_next = error_seen_reg || short_beat;
            end else begin
                error_next = error_seen_reg || (short_beat && !s_data.last_beat) || (|ovf);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_base_reg   <= '0;
            run_started_reg <= 1'b0;
            error_seen_reg  <= 1'b0;
        end else if (accept) begin
            if (s_data.last_beat) begin
                beat_base_reg   <= '0;
                run_started_reg <= 1'b0;
                error_seen_reg  <= 1'b0;
            end else begin
                beat_base_reg   <= first ? '0 : base_wide[INDEX_BITS-1:0];
                run_started_reg <= 1'b1;
                error_seen_reg  <= error_next;
            end
        end
    end

    lmma_merge #(
        .LANES      (LANES),
        .INDEX_BITS (INDEX_BITS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (accept && s_data.last_beat),
        .err_in   (error_next),
        .high_in  (high_next),
        .low_in   (low_next),
        .pos_in   (pos_next),
        .can_take (can_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/lmma_checker.sv @@
// ----------------------------------------------------------------------------
// lmma_checker
// port-level checks for lane_min_max_argmax_unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "lane_min_max_argmax_unit_assert.svh"

module lmma_checker (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_valid,
    input wire                      s_ready,
    input wire lmma_pkg::in_word_t  s_data,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire lmma_pkg::out_word_t m_data
);

    `LMMA_HOLD(a_out_hold, m_valid, m_ready, m_data)
    `LMMA_HOLD(a_in_hold, s_valid, s_ready, s_data)
    // no result survives a reset
    `LMMA_NEXT(a_reset_clears, !aresetn, !m_valid)
    // every accepted last word shows a result
    `LMMA_NEXT2(a_last_gives_result, s_valid && s_ready && s_data.last_beat, m_valid)

endmodule

bind lane_min_max_argmax_unit lmma_checker u_lmma_checker (.*);

`default_nettype wire
